// ===== rtl/core/vssp_pkg.sv =====
// Package for the volume size list parser: parser phase encoding, the
// parser state record and the character codes it recognizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vssp_pkg;

  // Parser phase between two bytes.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_NUMBER = 3'd1,
    PH_AFTER  = 3'd2,
    PH_SKIP   = 3'd3,
    PH_DONE   = 3'd4,
    PH_ERROR  = 3'd5
  } phase_t;

  // Complete parser state carried from one byte to the next.
  typedef struct packed {
    phase_t      phase;
    logic [63:0] acc;
    logic [63:0] first;
    logic        have_first;
    logic        cur_first;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:      PH_IDLE,
    acc:        64'd0,
    first:      64'd0,
    have_first: 1'b0,
    cur_first:  1'b0
  };

  // Character codes.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'h20;
  localparam logic [7:0] CH_UNIT_B  = 8'h62;
  localparam logic [7:0] CH_UNIT_K  = 8'h6B;
  localparam logic [7:0] CH_UNIT_M  = 8'h6D;
  localparam logic [7:0] CH_UNIT_G  = 8'h67;
  localparam logic [7:0] CH_UNIT_T  = 8'h74;

  // Unit shift amounts.
  localparam int SHIFT_K = 10;
  localparam int SHIFT_M = 20;
  localparam int SHIFT_G = 30;
  localparam int SHIFT_T = 40;

endpackage

`default_nettype wire

// ===== rtl/core/vssp_if.sv =====
// Valid/ready channel interfaces for the size list parser: one for text
// bytes and one for parse results. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface vssp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface vssp_size_if;
  logic        valid;
  logic        ready;
  logic        size_valid;
  logic [63:0] first_size;

  modport source (output valid, output size_valid, output first_size, input ready);
  modport sink (input valid, input size_valid, input first_size, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vssp_step.sv =====
// Next-state logic of the size list parser: applies one text byte to the
// parser state and forms the result on the final byte. Uses vssp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vssp_step (
  input  vssp_pkg::state_t cur,
  input  logic [7:0]       char_code,
  input  logic             last_char,
  output vssp_pkg::state_t nxt,
  output logic             size_valid,
  output logic [63:0]      first_size
);
  import vssp_pkg::*;

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Ends the number in progress; a zero value is an error.
  function automatic state_t close_number(state_t s);
    state_t r;
    r = s;
    if (s.acc == 64'd0) begin
      r.phase = PH_ERROR;
    end else begin
      if (!s.have_first) begin
        r.have_first = 1'b1;
        r.cur_first  = 1'b1;
        r.first      = s.acc;
      end else begin
        r.cur_first = 1'b0;
      end
      r.phase = PH_AFTER;
    end
    return r;
  endfunction

  // Starts a new token; only a digit may open one.
  function automatic state_t start_token(state_t s, logic [7:0] c);
    state_t r;
    r = s;
    if (is_digit(c)) begin
      r.acc   = {60'd0, c[3:0]};
      r.phase = PH_NUMBER;
    end else begin
      r.phase = PH_ERROR;
    end
    return r;
  endfunction

  // Handles a byte that follows a completed number (whitespace, dash, unit letter or new token).
  function automatic state_t after_number(state_t s, logic [7:0] c);
    state_t      r;
    logic [7:0]  low;
    logic [63:0] shifted;
    logic        shift_ovf;
    logic        is_unit;
    r         = s;
    low       = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_DELTA : c;
    is_unit   = 1'b1;
    shifted   = s.acc;
    shift_ovf = 1'b0;
    case (low)
      CH_UNIT_K: begin
        shifted   = s.acc << SHIFT_K;
        shift_ovf = |s.acc[63 -: SHIFT_K];
      end
      CH_UNIT_M: begin
        shifted   = s.acc << SHIFT_M;
        shift_ovf = |s.acc[63 -: SHIFT_M];
      end
      CH_UNIT_G: begin
        shifted   = s.acc << SHIFT_G;
        shift_ovf = |s.acc[63 -: SHIFT_G];
      end
      CH_UNIT_T: begin
        shifted   = s.acc << SHIFT_T;
        shift_ovf = |s.acc[63 -: SHIFT_T];
      end
      default: begin
        is_unit = 1'b0;
      end
    endcase
    if (is_ws(c)) begin
      r = s;
    end else if (c == CH_DASH) begin
      r.phase = PH_DONE;
    end else if (low == CH_UNIT_B) begin
      r.phase = PH_IDLE;
    end else if (is_unit) begin
      if (shift_ovf) begin
        r.phase = PH_ERROR;
      end else begin
        r.acc = shifted;
        if (s.cur_first) begin
          r.first = shifted;
        end
        r.phase = PH_SKIP;
      end
    end else begin
      r = start_token(s, c);
    end
    return r;
  endfunction

  // Multiply-add by ten with a carry-out check for 64-bit overflow.
  logic [67:0] acc_times_ten;
  logic        digit_ovf;

  assign acc_times_ten = ({4'd0, cur.acc} << 3) + ({4'd0, cur.acc} << 1)
                       + {64'd0, char_code[3:0]};
  assign digit_ovf     = |acc_times_ten[67:64];

  // Apply the byte, then close out the list on the final byte.
  state_t consumed;
  state_t closed;

  always_comb begin
    consumed = cur;
    case (cur.phase)
      PH_IDLE: begin
        if (is_ws(char_code)) begin
          consumed = cur;
        end else if (char_code == CH_DASH) begin
          consumed.phase = PH_DONE;
        end else begin
          consumed = start_token(cur, char_code);
        end
      end
      PH_NUMBER: begin
        if (is_digit(char_code)) begin
          if (digit_ovf) begin
            consumed.phase = PH_ERROR;
          end else begin
            consumed.acc = acc_times_ten[63:0];
          end
        end else begin
          consumed = close_number(cur);
          if (consumed.phase == PH_AFTER) begin
            consumed = after_number(consumed, char_code);
          end
        end
      end
      PH_AFTER: begin
        consumed = after_number(cur, char_code);
      end
      PH_SKIP: begin
        if (is_ws(char_code)) begin
          consumed.phase = PH_IDLE;
        end
      end
      PH_DONE: begin
        consumed = cur;
      end
      default: begin
        consumed.phase = PH_ERROR;
      end
    endcase

    closed = (consumed.phase == PH_NUMBER) ? close_number(consumed) : consumed;
    size_valid = (closed.phase != PH_ERROR) && closed.have_first;
    first_size = size_valid ? closed.first : 64'd0;
    nxt        = last_char ? STATE_RESET : consumed;
  end

endmodule

`default_nettype wire

// ===== rtl/core/volume_size_spec_parser.sv =====
// Volume size list parser, top level.
// A byte is registered in the byte stage at its transfer, and the result
// register loads when a final byte is applied to the parser state.
// Throughput: one byte per cycle; a final byte waits only while the previous
// result is still held. Each update does at most one multiply-by-ten add or one shift.
// Reset: synchronous, active high; clears parser state, byte stage and result.
`timescale 1ns / 1ps
`default_nettype none

module volume_size_spec_parser (
  input  logic        clk,
  input  logic        rst,
  vssp_char_if.sink   req,
  vssp_size_if.source rsp
);
  import vssp_pkg::*;

  // Byte stage.
  logic       stage_valid;
  logic [7:0] stage_char;
  logic       stage_last;
  logic       stage_fire;

  // Parser state.
  state_t      st;
  state_t      st_next;
  logic        res_size_valid;
  logic [63:0] res_first_size;

  // Result register.
  logic        out_valid;
  logic        out_size_valid;
  logic [63:0] out_first_size;

  // A byte is applied unless it is a final byte and the result register is held.
  assign stage_fire = stage_valid && (!stage_last || !out_valid || rsp.ready);
  assign req.ready  = !stage_valid || stage_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      stage_char <= req.char_code;
      stage_last <= req.last_char;
    end
  end

  vssp_step u_step (
    .cur        (st),
    .char_code  (stage_char),
    .last_char  (stage_last),
    .nxt        (st_next),
    .size_valid (res_size_valid),
    .first_size (res_first_size)
  );

  // Parser state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (stage_fire) begin
      st <= st_next;
    end
  end

  // Result register; a new result may load in the cycle the old one transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_fire && stage_last) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && stage_last) begin
      out_size_valid <= res_size_valid;
      out_first_size <= res_first_size;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.size_valid = out_size_valid;
  assign rsp.first_size = out_first_size;

  // A result is never loaded over one that has not been taken.
  assert property (@(posedge clk) disable iff (rst)
    (stage_fire && stage_last) |-> (!out_valid || rsp.ready))
    else $error("result register overwritten before transfer");

  // The parser starts afresh after every final byte.
  assert property (@(posedge clk) disable iff (rst)
    (stage_fire && stage_last) |=> (st.phase == PH_IDLE && !st.have_first))
    else $error("parser state not cleared after final byte");

  // A recorded first size is never zero.
  assert property (@(posedge clk) disable iff (rst)
    st.have_first |-> (st.first != 64'd0))
    else $error("first size recorded as zero");

  // An invalid result carries a zero size.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_size_valid) |-> (out_first_size == 64'd0))
    else $error("invalid result with nonzero size");

endmodule

`default_nettype wire
